/* sv/grid_last_local_minimum_assert.svh */
// Assertion macros included by the RTL file of the block.
`ifndef GRID_LAST_LOCAL_MINIMUM_ASSERT_SVH
`define GRID_LAST_LOCAL_MINIMUM_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks that an expression holds at every clock edge outside reset.
`define GLLM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("always-true check failed");

// Checks that a condition in one cycle is followed by another in the next.
`define GLLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define GLLM_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define GLLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/gllm_pkg.sv */
`default_nettype none

package gllm_pkg;

    localparam int ELEM_W     = 32;
    localparam int POS_W      = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

endpackage

`default_nettype wire

/* sv/gllm_if.sv */
`default_nettype none

// Input channel: one matrix element per word.
interface gllm_in_if;
    import gllm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// Output channel: one result word per matrix.
interface gllm_out_if;
    import gllm_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] min_row;
    logic [POS_W-1:0] min_col;

    modport source (output valid, output found, output min_row, output min_col, input ready);
    modport sink   (input valid, input found, input min_row, input min_col, output ready);
endinterface

`default_nettype wire

/* sv/gllm_ram.sv */
`default_nettype none

module gllm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/grid_last_local_minimum.sv */
`default_nettype none

// Finds the last 4-neighbor local minimum of a signed matrix in raster order.
// Elements arrive row-major, one word per cycle while loading, into a single
// block RAM of 2**(RW+CW) entries, MAX_ROWS x MAX_COLS each rounded up to a
// power of two (row_count and col_count are clamped to 2..MAX). Once the last
// element is in, the block stops taking words and scans every cell through
// the RAM's one read port: the center and its four neighbor addresses are read
// one after another and compared by a single comparator, phase by phase
// (CTR, UP, DN, LF, RT, END). The result word is then held until taken, after
// which loading resumes. A write to the row or column count restarts the load
// at row 0, column 0. No clearing pass is run after reset.
module grid_last_local_minimum #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [gllm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [gllm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gllm_in_if.sink                          i_elem,
    gllm_out_if.source                       o_res
);
    import gllm_pkg::*;

    `include "grid_last_local_minimum_assert.svh"

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    // Read issued in each phase; the data of a phase arrives in the next one.
    typedef enum logic [2:0] {
        PH_CTR = 3'd0,
        PH_UP  = 3'd1,
        PH_DN  = 3'd2,
        PH_LF  = 3'd3,
        PH_RT  = 3'd4,
        PH_END = 3'd5
    } t_phase;

    t_state                   r_state;
    t_phase                   r_ph, n_ph;
    logic [DRW-1:0]           r_rows;
    logic [DCW-1:0]           r_cols;
    logic [RW-1:0]            r_load_row;
    logic [CW-1:0]            r_load_col;
    logic [RW-1:0]            r_row;
    logic [CW-1:0]            r_col;
    logic signed [ELEM_W-1:0] r_center;
    logic                     r_exist;
    logic                     r_ok;
    logic                     r_found;
    logic [POS_W-1:0]         r_fr;
    logic [POS_W-1:0]         r_fc;

    logic [DRW-1:0]           cfg_rows;
    logic [DCW-1:0]           cfg_cols;
    logic [RW-1:0]            eff_row;
    logic [CW-1:0]            eff_col;
    logic                     in_acc;
    logic                     load_last_col;
    logic                     load_last_row;
    logic [AW-1:0]            raddr;
    logic                     exist_issue;
    logic [ELEM_W-1:0]        rdata;
    logic                     nb_fail;
    logic                     cell_min;
    logic                     scan_last_col;
    logic                     scan_last_row;

    // Clamp the written dimension to the supported range.
    always_comb begin
        if (i_cfg_data < CFG_DATA_W'(2)) begin
            cfg_rows = DRW'(2);
        end else if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
            cfg_rows = DRW'(MAX_ROWS);
        end else begin
            cfg_rows = DRW'(i_cfg_data);
        end
        if (i_cfg_data < CFG_DATA_W'(2)) begin
            cfg_cols = DCW'(2);
        end else if (32'(i_cfg_data) > 32'(MAX_COLS)) begin
            cfg_cols = DCW'(MAX_COLS);
        end else begin
            cfg_cols = DCW'(i_cfg_data);
        end
    end

    assign i_elem.ready = (r_state == S_LOAD);
    assign in_acc       = i_elem.valid && i_elem.ready;

    always_comb begin
        if (DRW'(r_load_row) >= r_rows || DCW'(r_load_col) >= r_cols) begin
            eff_row = '0;
            eff_col = '0;
        end else begin
            eff_row = r_load_row;
            eff_col = r_load_col;
        end
    end

    assign load_last_col = (DCW'(eff_col) + DCW'(1)) == r_cols;
    assign load_last_row = (DRW'(eff_row) + DRW'(1)) == r_rows;
    assign scan_last_col = (DCW'(r_col) + DCW'(1)) == r_cols;
    assign scan_last_row = (DRW'(r_row) + DRW'(1)) == r_rows;

    // Neighbor address and whether that neighbor lies inside the matrix.
    always_comb begin
        raddr       = {r_row, r_col};
        exist_issue = 1'b0;
        unique case (r_ph)
            PH_CTR: begin
                raddr       = {r_row, r_col};
                exist_issue = 1'b0;
            end
            PH_UP: begin
                raddr       = {r_row - RW'(1), r_col};
                exist_issue = (r_row != '0);
            end
            PH_DN: begin
                raddr       = {r_row + RW'(1), r_col};
                exist_issue = !scan_last_row;
            end
            PH_LF: begin
                raddr       = {r_row, r_col - CW'(1)};
                exist_issue = (r_col != '0);
            end
            PH_RT: begin
                raddr       = {r_row, r_col + CW'(1)};
                exist_issue = !scan_last_col;
            end
            PH_END: begin
                raddr       = {r_row, r_col};
                exist_issue = 1'b0;
            end
            default: begin
                raddr       = {r_row, r_col};
                exist_issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_ph)
            PH_CTR:  n_ph = PH_UP;
            PH_UP:   n_ph = PH_DN;
            PH_DN:   n_ph = PH_LF;
            PH_LF:   n_ph = PH_RT;
            PH_RT:   n_ph = PH_END;
            PH_END:  n_ph = PH_CTR;
            default: n_ph = PH_CTR;
        endcase
    end

    gllm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr ({eff_row, eff_col}),
        .i_wdata (i_elem.element_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The one comparator: a neighbor that exists and is not above the center fails it.
    assign nb_fail  = r_exist && !(r_center < $signed(rdata));
    assign cell_min = r_ok && !nb_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_ph       <= PH_CTR;
            r_rows     <= DRW'(2);
            r_cols     <= DCW'(2);
            r_load_row <= '0;
            r_load_col <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_exist    <= 1'b0;
            r_ok       <= 1'b0;
            r_found    <= 1'b0;
            r_fr       <= '0;
            r_fc       <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_ROW_COUNT || i_cfg_idx == CFG_COL_COUNT)) begin
                if (i_cfg_idx == CFG_ROW_COUNT) begin
                    r_rows <= cfg_rows;
                end else begin
                    r_cols <= cfg_cols;
                end
                r_load_row <= '0;
                r_load_col <= '0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (!load_last_col) begin
                            r_load_row <= eff_row;
                            r_load_col <= eff_col + CW'(1);
                        end else if (!load_last_row) begin
                            r_load_row <= eff_row + RW'(1);
                            r_load_col <= '0;
                        end else begin
                            r_load_row <= '0;
                            r_load_col <= '0;
                            r_state    <= S_SCAN;
                            r_ph       <= PH_CTR;
                            r_row      <= '0;
                            r_col      <= '0;
                            r_found    <= 1'b0;
                            r_fr       <= '0;
                            r_fc       <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_exist <= exist_issue;
                    r_ph    <= n_ph;
                    if (r_ph == PH_UP) begin
                        r_center <= $signed(rdata);
                        r_ok     <= 1'b1;
                    end else if (r_ph != PH_CTR && nb_fail) begin
                        r_ok <= 1'b0;
                    end
                    if (r_ph == PH_END) begin
                        if (cell_min) begin
                            r_found <= 1'b1;
                            r_fr    <= POS_W'(r_row);
                            r_fc    <= POS_W'(r_col);
                        end
                        if (!scan_last_col) begin
                            r_col <= r_col + CW'(1);
                        end else begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                            if (scan_last_row) begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid   = (r_state == S_OUT);
    assign o_res.found   = r_found;
    assign o_res.min_row = r_fr;
    assign o_res.min_col = r_fc;

    `GLLM_ASSERT_ALWAYS(a_no_load_while_result, i_clk, i_rst_n, !(i_elem.ready && o_res.valid))
    `GLLM_ASSERT_ALWAYS(a_none_reads_zero, i_clk, i_rst_n,
        !(o_res.valid && !o_res.found) || (o_res.min_row == '0 && o_res.min_col == '0))
    `GLLM_ASSERT_NEXT(a_resume_after_result, i_clk, i_rst_n,
        o_res.valid && o_res.ready, i_elem.ready && !o_res.valid)
    `GLLM_ASSERT_ALWAYS(a_scan_in_range, i_clk, i_rst_n,
        !(r_state == S_SCAN) || (DRW'(r_row) < r_rows && DCW'(r_col) < r_cols))

endmodule

`default_nettype wire
